// ===== hdl/triangle_scanline_span_generator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the triangle span generator
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define TSSG_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define TSSG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== hdl/tssg_pkg.sv =====
// ---------------------------------------------------------------------------
// tssg_pkg
// Shared types and constants of the triangle span generator.
// ---------------------------------------------------------------------------
package tssg_pkg;
  localparam int CoordW = 20;
  localparam int PixW   = 16;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture triangle
    logic       map_step;  // map one coordinate (index in map_idx)
    logic [2:0] map_idx;
    logic       sort;      // sort mapped vertices
    logic       row_init;  // set first row
    logic       edge_start;// start one edge division
    logic       edge_sel;  // 0: left edge, 1: right edge
    logic [1:0] half;      // 1 upper, 2 lower
    logic       emit;      // build span into output register
    logic       row_next;  // advance row
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic rows_left;  // current row within current half
    logic lower_ok;   // lower half exists
    logic row_limit;  // span count reached cap
    logic last_in_tri;// this row is the last of the triangle
  } ctl_sts_t;
endpackage

// ===== hdl/triangle_scanline_span_generator_unit.sv =====
// ---------------------------------------------------------------------------
// triangle_scanline_span_generator_unit
// Scanline triangle walker emitting one clipped span per map row.
// ---------------------------------------------------------------------------
// Usage: write coord_scale, coord_offset, map_width, map_height through the
// cfg channel (index 0..3) while idle. Present a triangle on the input
// channel; it is taken when in_valid is high and in_stall low. The block
// then emits up to MAX_DIM span beats, the final one flagged by last_span;
// a triangle wholly off the map rows gives no beat.
// Sequence: the vertices are mapped and sorted first, then per row there is
// a left and a right edge evaluation, each a multiply step, an x and a k
// division in series on the shared divider and a finish step (the divisions
// are skipped when an edge's height is not positive); one triangle at a time.
// in_stall stays high until the triangle's last span has been taken.
// When the receiver raises out_stall the span beat holds unchanged.
// Reset (rst, synchronous) returns to idle and restores register defaults.
// ---------------------------------------------------------------------------
module triangle_scanline_span_generator_unit #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] a_u,
  input  logic signed [19:0] a_v,
  input  logic signed [19:0] b_u,
  input  logic signed [19:0] b_v,
  input  logic signed [19:0] c_u,
  input  logic signed [19:0] c_v,
  input  logic [7:0]         material_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         row,
  output logic [14:0]        first_x,
  output logic signed [15:0] final_x,
  output logic signed [15:0] left_x,
  output logic signed [15:0] right_x,
  output logic [16:0]        left_weight_a,
  output logic [16:0]        left_weight_b,
  output logic [16:0]        right_weight_a,
  output logic [16:0]        right_weight_b,
  output logic               span_empty,
  output logic [7:0]         span_material,
  output logic               last_span
);
  tssg_pkg::ctl_cmd_t cmd;
  tssg_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  tssg_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .last_span(last_span),
    .cmd(cmd), .sts(sts)
  );

  tssg_datapath #(.MaxDim(MAX_DIM), .FracBits(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .a_u(a_u), .a_v(a_v), .b_u(b_u), .b_v(b_v), .c_u(c_u), .c_v(c_v),
    .material_id(material_id),
    .row(row), .first_x(first_x), .final_x(final_x), .left_x(left_x),
    .right_x(right_x), .left_weight_a(left_weight_a),
    .left_weight_b(left_weight_b), .right_weight_a(right_weight_a),
    .right_weight_b(right_weight_b), .span_empty(span_empty),
    .span_material(span_material)
  );
endmodule

// ===== hdl/tssg_divider.sv =====
// ---------------------------------------------------------------------------
// tssg_divider
// Restoring signed divider, truncating quotient, one bit per cycle.
// ---------------------------------------------------------------------------
module tssg_divider #(
  parameter int NumW = 48,
  parameter int DenW = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DenW-1:0] den,
  output logic                   done,
  output logic signed [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [NumW:0]   rem;
  logic [DenW-1:0] d;
  logic            neg;
  logic            busy;
  logic [CntW-1:0] cnt;
  logic [NumW:0]   trial;

  assign trial = {rem[NumW-1:0], q[NumW-1]} - {{(NumW+1-DenW){1'b0}}, d};

  // shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num[NumW-1] ? NumW'(-num) : num;
      d   <= den[DenW-1] ? DenW'(-den) : den;
      neg <= num[NumW-1] ^ den[DenW-1];
      rem <= '0;
    end else if (busy) begin
      if (!trial[NumW]) begin
        rem <= trial;
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= {rem[NumW-1:0], q[NumW-1]};
        q   <= {q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? NumW'(-q) : q;
endmodule

// ===== hdl/tssg_datapath.sv =====
// ---------------------------------------------------------------------------
// tssg_datapath
// Coordinate mapping, vertex sort, edge evaluation and span register.
// ---------------------------------------------------------------------------
module tssg_datapath #(
  parameter int MaxDim   = 64,
  parameter int FracBits = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tssg_pkg::ctl_cmd_t         cmd,
  output tssg_pkg::ctl_sts_t         sts,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic signed [19:0]         a_u,
  input  logic signed [19:0]         a_v,
  input  logic signed [19:0]         b_u,
  input  logic signed [19:0]         b_v,
  input  logic signed [19:0]         c_u,
  input  logic signed [19:0]         c_v,
  input  logic [7:0]                 material_id,
  output logic [5:0]                 row,
  output logic [14:0]                first_x,
  output logic signed [15:0]         final_x,
  output logic signed [15:0]         left_x,
  output logic signed [15:0]         right_x,
  output logic [16:0]                left_weight_a,
  output logic [16:0]                left_weight_b,
  output logic [16:0]                right_weight_a,
  output logic [16:0]                right_weight_b,
  output logic                       span_empty,
  output logic [7:0]                 span_material
);
  localparam int DimW  = $clog2(MaxDim + 1);
  localparam int CntW  = $clog2(MaxDim + 1);
  localparam int SzW   = (DimW > 7) ? DimW : 7;
  // scale*c needs 40 bits, offset*ONE needs 20+FracBits, plus a carry
  localparam int ProdW = (FracBits > 19) ? FracBits + 21 : 41;
  localparam int ExW   = ProdW + SzW + 1;            // exact mapped value
  localparam int NumW  = 34 + FracBits;              // edge numerators
  localparam int OneW  = FracBits + 2;
  localparam logic signed [OneW-1:0] One = OneW'(1) <<< FracBits;

  // configuration registers
  logic signed [19:0] scale, offset;
  logic [6:0]         width_raw, height_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= 20'sd65536;
      offset     <= '0;
      width_raw  <= 7'd64;
      height_raw <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tssg_pkg::REG_SCALE:  scale      <= cfg_data[19:0];
        tssg_pkg::REG_OFFSET: offset     <= cfg_data[19:0];
        tssg_pkg::REG_WIDTH:  width_raw  <= cfg_data[6:0];
        tssg_pkg::REG_HEIGHT: height_raw <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp map size to 1..MaxDim
  logic [SzW:0] wd, ht;
  always_comb begin
    wd = (width_raw == 7'd0) ? (SzW+1)'(1) :
         ((SzW+1)'(width_raw) > (SzW+1)'(MaxDim)) ? (SzW+1)'(MaxDim) : (SzW+1)'(width_raw);
    ht = (height_raw == 7'd0) ? (SzW+1)'(1) :
         ((SzW+1)'(height_raw) > (SzW+1)'(MaxDim)) ? (SzW+1)'(MaxDim) : (SzW+1)'(height_raw);
  end

  // captured triangle
  logic signed [19:0] coord [6];
  logic [7:0]         mtl;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coord[0] <= a_u; coord[1] <= a_v;
      coord[2] <= b_u; coord[3] <= b_v;
      coord[4] <= c_u; coord[5] <= c_v;
      mtl      <= material_id;
    end
  end

  // map one coordinate: product registered, then multiply by size
  logic signed [ExW-1:0]  exact [6];
  logic signed [ProdW-1:0] prod;
  logic signed [39:0]      sc_c;
  logic [2:0]              pidx;
  logic                    pvalid;
  logic signed [ExW-1:0]   ex_n;
  assign sc_c = scale * coord[cmd.map_idx];
  always_comb begin
    ex_n = ExW'(prod) * $signed({1'b0, (pidx[0] ? ht : wd)});
  end
  always_ff @(posedge clk) begin
    if (rst) pvalid <= 1'b0;
    else     pvalid <= cmd.map_step;
    if (cmd.map_step) begin
      prod <= ProdW'(sc_c) + (ProdW'(offset) <<< FracBits);
      pidx <= cmd.map_idx;
    end
    if (pvalid) exact[pidx] <= ex_n;
  end

  // saturate exact value to a pixel, truncating toward zero
  function automatic logic signed [15:0] to_pix(input logic signed [ExW-1:0] e);
    logic signed [ExW-1:0] p;
    begin
      p = (e < 0) ? -((-e) >>> (2*FracBits)) : (e >>> (2*FracBits));
      if (p > 32767)       to_pix = 16'sh7fff;
      else if (p < -32768) to_pix = 16'sh8000;
      else                 to_pix = p[15:0];
    end
  endfunction

  // sorted vertices
  logic signed [15:0] su [3], sv [3];
  logic [1:0]         ord [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      ord[0] <= 2'd0; ord[1] <= 2'd0; ord[2] <= 2'd0;
    end else if (cmd.sort) begin
      logic [1:0] o0, o1, o2, t;
      o0 = 2'd0; o1 = 2'd1; o2 = 2'd2;
      if (exact[2*o0+1] > exact[2*o1+1]) begin t = o0; o0 = o1; o1 = t; end
      if (exact[2*o0+1] > exact[2*o2+1]) begin t = o0; o0 = o2; o2 = t; end
      if (exact[2*o1] > exact[2*o2]) begin t = o1; o1 = o2; o2 = t; end
      ord[0] <= o0; ord[1] <= o1; ord[2] <= o2;
      su[0] <= to_pix(exact[2*o0]); sv[0] <= to_pix(exact[2*o0+1]);
      su[1] <= to_pix(exact[2*o1]); sv[1] <= to_pix(exact[2*o1+1]);
      su[2] <= to_pix(exact[2*o2]); sv[2] <= to_pix(exact[2*o2+1]);
    end
  end

  // row walk
  logic signed [16:0] y;
  logic [CntW-1:0]    nspan;
  logic signed [16:0] ey_up, ey_lo, ht_m1, wd_m1;
  logic               flat_split;
  assign ht_m1      = 17'(ht) - 17'sd1;
  assign wd_m1      = 17'(wd) - 17'sd1;
  assign flat_split = sv[1] > sv[2];
  assign ey_up = flat_split ? ((17'(sv[2]) < ht_m1) ? 17'(sv[2]) : ht_m1)
                            : ((17'(sv[1]) < ht_m1) ? 17'(sv[1]) : ht_m1);
  assign ey_lo = flat_split ? ((17'(sv[1]) < ht_m1) ? 17'(sv[1]) : ht_m1)
                            : ((17'(sv[2]) < ht_m1) ? 17'(sv[2]) : ht_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      y     <= '0;
      nspan <= '0;
    end else if (cmd.row_init) begin
      y     <= (sv[0] < 0) ? 17'sd0 : 17'(sv[0]);
      nspan <= '0;
    end else if (cmd.row_next) begin
      y     <= y + 17'sd1;
      nspan <= nspan + CntW'(1);
    end
  end

  logic [CntW-1:0]    cap;
  logic signed [16:0] yn;
  assign cap = CntW'(MaxDim);
  assign yn  = y + 17'sd1;
  assign sts.rows_left = (cmd.half == 2'd1) ? (y <= ey_up) : (y <= ey_lo);
  assign sts.lower_ok  = flat_split || (17'(sv[2]) - 17'(sv[1]) > 0);
  assign sts.row_limit = (nspan >= cap);
  // last if next row ends both halves or hits the cap
  assign sts.last_in_tri = (nspan + CntW'(1) >= cap) ||
                           ((cmd.half == 2'd1) ?
                              (!(yn <= ey_up) && !(sts.lower_ok && yn <= ey_lo)) :
                              !(yn <= ey_lo));

  // choose edge endpoints by half and side
  logic [1:0] s0, s1;
  always_comb begin
    s0 = 2'd0; s1 = 2'd1;
    if (cmd.edge_sel) begin
      if (cmd.half == 2'd2 && flat_split) begin s0 = 2'd2; s1 = 2'd1; end
      else begin s0 = 2'd0; s1 = 2'd2; end
    end else if (cmd.half == 2'd2 && !flat_split) begin
      s0 = 2'd1; s1 = 2'd2;
    end
  end

  // edge numerators, two divisions through one divider
  logic signed [17:0]     h, tt;
  logic signed [16:0]     du;
  logic signed [33:0]     pm_n;
  logic signed [34:0]     qm_n;
  logic signed [NumW-1:0] xnum, knum, dnum, quo;
  logic                   dstart, ddone;
  assign h    = 18'(sv[s1]) - 18'(sv[s0]);
  assign tt   = 18'(y) - 18'(sv[s0]);
  assign du   = 17'(su[s1]) - 17'(su[s0]);
  assign knum = NumW'(tt) <<< FracBits;
  assign pm_n = su[s0] * h;
  assign qm_n = du * tt;
  logic signed [NumW-1:0] pmul, qmul;
  always_ff @(posedge clk) begin
    if (cmd.edge_start) begin
      pmul <= NumW'(pm_n);
      qmul <= NumW'(qm_n);
    end
  end

  // edge sequencing: multiply, x divide, k divide
  logic signed [17:0] hr;
  logic               hpos;
  logic [1:0]         v0, v1;
  logic signed [15:0] qu_r;
  logic [2:0]         st;
  localparam logic [2:0] E_IDLE = 3'd0, E_MUL = 3'd1, E_XDIV = 3'd2, E_KDIV = 3'd3,
                         E_DONE = 3'd4;
  logic signed [NumW-1:0] xq;
  logic signed [OneW-1:0] kq;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= E_IDLE;
    end else begin
      unique case (st)
        E_IDLE: if (cmd.edge_start) st <= E_MUL;
        E_MUL:  st <= hpos ? E_XDIV : E_DONE;
        E_XDIV: if (ddone) st <= E_KDIV;
        E_KDIV: if (ddone) st <= E_DONE;
        E_DONE: st <= E_IDLE;
        default: st <= E_IDLE;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.edge_start) begin
      hr   <= h;
      hpos <= h > 0;
      v0   <= ord[s0];
      v1   <= ord[s1];
      qu_r <= su[s1];
      dnum <= knum;
    end
    if (st == E_XDIV && ddone) xq <= quo;
    if (st == E_KDIV && ddone) kq <= OneW'(quo);
    if (st == E_MUL && !hpos) begin
      xq <= NumW'(qu_r);
      kq <= One;
    end
  end
  assign dstart  = (st == E_MUL && hpos) || (st == E_XDIV && ddone);
  assign xnum    = (st == E_MUL) ? pmul + qmul : dnum;
  assign sts.div_done = (st == E_DONE);

  tssg_divider #(.NumW(NumW), .DenW(18)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(xnum), .den(hr),
    .done(ddone), .quo(quo)
  );

  // per-edge results, weights on A/B
  logic signed [15:0] ex_l, ex_r;
  logic [16:0]        wa_l, wb_l, wa_r, wb_r;
  logic [16:0]        wa_n, wb_n, wp, wq;
  always_comb begin
    wp = 17'(One - kq);
    wq = 17'(kq);
    wa_n = ((v0 == 2'd0) ? wp : 17'd0) + ((v1 == 2'd0) ? wq : 17'd0);
    wb_n = ((v0 == 2'd1) ? wp : 17'd0) + ((v1 == 2'd1) ? wq : 17'd0);
  end
  always_ff @(posedge clk) begin
    if (st == E_DONE) begin
      if (cmd.edge_sel) begin
        ex_r <= xq[15:0]; wa_r <= wa_n; wb_r <= wb_n;
      end else begin
        ex_l <= xq[15:0]; wa_l <= wa_n; wb_l <= wb_n;
      end
    end
  end

  // build span: order ends, clip
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      logic signed [15:0] x1, x2, sx, e;
      logic               sw;
      sw = ex_l > ex_r;
      x1 = sw ? ex_r : ex_l;
      x2 = sw ? ex_l : ex_r;
      sx = (x1 < 0) ? 16'sd0 : x1;
      e  = (17'(x2) > wd_m1) ? wd_m1[15:0] : x2;
      row            <= y[5:0];
      first_x        <= sx[14:0];
      final_x        <= e;
      left_x         <= x1;
      right_x        <= x2;
      left_weight_a  <= sw ? wa_r : wa_l;
      left_weight_b  <= sw ? wb_r : wb_l;
      right_weight_a <= sw ? wa_l : wa_r;
      right_weight_b <= sw ? wb_l : wb_r;
      span_empty     <= sx > e;
      span_material  <= mtl;
    end
  end
endmodule

// ===== hdl/tssg_control.sv =====
// ---------------------------------------------------------------------------
// tssg_control
// Sequencer: map, sort, then per row a left and a right edge evaluation and a span.
// ---------------------------------------------------------------------------
`include "triangle_scanline_span_generator_unit_macros.svh"
module tssg_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               last_span,
  output tssg_pkg::ctl_cmd_t cmd,
  input  tssg_pkg::ctl_sts_t sts
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAP   = 4'd1;
  localparam logic [3:0] S_SORT  = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_ROW   = 4'd4;
  localparam logic [3:0] S_LEFT  = 4'd5;
  localparam logic [3:0] S_WL    = 4'd6;
  localparam logic [3:0] S_RIGHT = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;

  logic [3:0] state, state_next;
  logic [3:0] mcnt;
  logic [1:0] half;
  logic       last_r;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.half       = half;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.map_step   = (state == S_MAP) && (mcnt < 4'd6);
    cmd.map_idx    = mcnt[2:0];
    cmd.sort       = (state == S_SORT);
    cmd.row_init   = (state == S_INIT);
    cmd.edge_start = (state == S_LEFT) || (state == S_RIGHT);
    cmd.edge_sel   = (state == S_RIGHT) || (state == S_WR) || (state == S_HOLD);
    cmd.emit       = (state == S_HOLD);
    cmd.row_next   = (state == S_EMIT) && !out_stall;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MAP;
      S_MAP:   if (mcnt == 4'd7) state_next = S_SORT;
      S_SORT:  state_next = S_INIT;
      S_INIT:  state_next = S_ROW;
      S_ROW: begin
        if (sts.row_limit) state_next = S_IDLE;
        else if (sts.rows_left) state_next = S_LEFT;
        else if (half == 2'd1 && sts.lower_ok) state_next = S_ROW;
        else state_next = S_IDLE;
      end
      S_LEFT:  state_next = S_WL;
      S_WL:    if (sts.div_done) state_next = S_RIGHT;
      S_RIGHT: state_next = S_WR;
      S_WR:    if (sts.div_done) state_next = S_HOLD;
      S_HOLD:  state_next = S_EMIT;
      S_EMIT:  if (!out_stall) state_next = S_ROW;
      default: state_next = S_IDLE;
    endcase
  end

  // state, map counter, half and last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mcnt   <= '0;
      half   <= 2'd0;
      last_r <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) mcnt <= '0;
      else if (state == S_MAP) mcnt <= mcnt + 4'd1;
      if (state == S_INIT) half <= 2'd1;
      else if (state == S_ROW && !sts.rows_left && half == 2'd1) half <= 2'd2;
      else if (state_next == S_IDLE) half <= 2'd0;
      if (state == S_HOLD) last_r <= sts.last_in_tri;
    end
  end

  assign out_valid = (state == S_EMIT);
  assign last_span = last_r;

  `TSSG_ASSERT_IMP(a_stall_busy, clk, rst, state != S_IDLE, in_stall,
    "input taken while busy")
  `TSSG_ASSERT_NEXT(a_hold_span, clk, rst, out_valid && out_stall, out_valid,
    "span dropped under stall")
  `TSSG_ASSERT_IMP(a_emit_half, clk, rst, out_valid, half == 2'd1 || half == 2'd2,
    "span outside a half")
endmodule
